@@ rtl/gm3_pkg.sv @@
`timescale 1ns / 1ps
package gm3_pkg;

  localparam int CFG_DW = 11;

  typedef logic [1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_MODE   = 2'd0;
  localparam cfg_idx_t CFG_WIDTH  = 2'd1;
  localparam cfg_idx_t CFG_HEIGHT = 2'd2;

  localparam logic [7:0] PIX_MAX = 8'hFF;

  // neighbour validity and frame-last flag for one output position
  typedef struct packed {
    logic top_ok;
    logic bot_ok;
    logic left_ok;
    logic right_ok;
    logic last;
  } win_ctl_t;

  // max when use_min is low, min otherwise
  function automatic logic [7:0] pick(input logic [7:0] a, input logic [7:0] b,
                                      input logic use_min);
    if (use_min) begin
      return (a < b) ? a : b;
    end
    return (a > b) ? a : b;
  endfunction

endpackage

@@ rtl/gm3_ram.sv @@
`timescale 1ns / 1ps
module gm3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/grey_morph_3x3_minmax_top.sv @@
`timescale 1ns / 1ps
// 3x3 greyscale max/min filter over the eight neighbours of each pixel.
// Throughput: one item per cycle while s_tready is high; two line-store RAMs
// are read on accept, written the cycle after, with same-column forwarding.
// A result passes the line-store and reduce stages and then the output queue;
// results trail the stream by one row plus one pixel.
// Reset (rst, synchronous): counters, window and output queue clear, mode
// goes to max, size to 640x480; line stores are not cleared.
module grey_morph_3x3_minmax_top #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [7:0]                s_tdata,   // [7:0] pixel_in
  input  logic                      s_tuser,   // [0] action
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [7:0]                m_tdata,   // [7:0] pixel_out
  output logic                      m_tlast,
  input  logic                      cfg_we,
  input  gm3_pkg::cfg_idx_t         cfg_index,
  input  logic [gm3_pkg::CFG_DW-1:0] cfg_data
);
  import gm3_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int DEPTH = 4;
  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  function automatic int clamp_dim(input int v, input int hi);
    if (v == 0) begin
      return 1;
    end else if (v > hi) begin
      return hi;
    end
    return v;
  endfunction

  localparam logic [WW-1:0] W_RST = WW'(clamp_dim(640, MAX_WIDTH));
  localparam logic [HW-1:0] H_RST = HW'(clamp_dim(480, MAX_HEIGHT));

  // configuration
  logic          fmode;
  logic [WW-1:0] w_c;
  logic [HW-1:0] h_c;
  logic          restart_cfg;

  assign restart_cfg = cfg_we && (cfg_index == CFG_WIDTH || cfg_index == CFG_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      fmode <= 1'b0;
      w_c   <= W_RST;
      h_c   <= H_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODE:   fmode <= cfg_data[0];
        CFG_WIDTH:  w_c   <= WW'(clamp_dim(int'(cfg_data), MAX_WIDTH));
        CFG_HEIGHT: h_c   <= HW'(clamp_dim(int'(cfg_data), MAX_HEIGHT));
        default: ;
      endcase
    end
  end

  // accept stage: frame counters and output position
  logic [AW-1:0] in_column;
  logic [HW-1:0] in_row;
  logic [WW:0]   pcount;
  logic [AW-1:0] out_col;
  logic [HW-1:0] out_row;

  logic          accept, filling, go, emit0;
  logic [7:0]    pix0;
  logic [WW-1:0] col_inc;
  logic [WW:0]   prime_cnt;
  win_ctl_t      ctl0;

  assign accept    = s_tvalid && s_tready;
  assign filling   = in_row < h_c;
  assign go        = accept && !(filling && s_tuser);
  assign pix0      = filling ? s_tdata : 8'd0;
  assign col_inc   = WW'(in_column) + WW'(1);
  assign prime_cnt = (WW+1)'(w_c) + (WW+1)'(1);
  assign emit0     = (pcount == prime_cnt);

  always_comb begin
    ctl0.top_ok   = (out_row != '0);
    ctl0.bot_ok   = ((out_row + HW'(1)) != h_c);
    ctl0.left_ok  = (out_col != '0);
    ctl0.right_ok = ((WW'(out_col) + WW'(1)) != w_c);
    ctl0.last     = !ctl0.bot_ok && !ctl0.right_ok;
  end

  always_ff @(posedge clk) begin
    if (rst || restart_cfg) begin
      in_column <= '0;
      in_row    <= '0;
      pcount    <= '0;
      out_col   <= '0;
      out_row   <= '0;
    end else if (go) begin
      if (col_inc >= w_c) begin
        in_column <= '0;
        if (filling) begin
          in_row <= in_row + HW'(1);
        end
      end else begin
        in_column <= col_inc[AW-1:0];
      end
      if (!emit0) begin
        pcount <= pcount + (WW+1)'(1);
      end
      if (emit0) begin
        if (ctl0.last) begin
          // frame done: start over on the next item
          in_column <= '0;
          in_row    <= '0;
          pcount    <= '0;
          out_col   <= '0;
          out_row   <= '0;
        end else if (ctl0.right_ok) begin
          out_col <= out_col + AW'(1);
        end else begin
          out_col <= '0;
          out_row <= out_row + HW'(1);
        end
      end
    end
  end

  // line-store stage
  logic          v1, e1;
  logic [AW-1:0] col1;
  logic [7:0]    pix1;
  win_ctl_t      ctl1;
  logic [7:0]    up_rdata, mid_rdata, top1, mid1;
  logic          wr_v, fwd;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_up, wr_mid;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      e1   <= 1'b0;
      wr_v <= 1'b0;
    end else begin
      v1   <= go;
      e1   <= go && emit0;
      wr_v <= v1;
    end
  end

  always_ff @(posedge clk) begin
    col1    <= in_column;
    pix1    <= pix0;
    ctl1    <= ctl0;
    wr_addr <= col1;
    wr_up   <= mid1;
    wr_mid  <= pix1;
  end

  // RAM read missed the write of the item just ahead at the same column
  assign fwd  = wr_v && (wr_addr == col1);
  assign top1 = fwd ? wr_up  : up_rdata;
  assign mid1 = fwd ? wr_mid : mid_rdata;

  gm3_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_upper (
    .clk   (clk),
    .we    (v1),
    .waddr (col1),
    .wdata (mid1),
    .raddr (in_column),
    .rdata (up_rdata)
  );

  gm3_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_middle (
    .clk   (clk),
    .we    (v1),
    .waddr (col1),
    .wdata (pix1),
    .raddr (in_column),
    .rdata (mid_rdata)
  );

  logic [7:0] win [9];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) begin
        win[i] <= '0;
      end
    end else if (v1) begin
      for (int k = 0; k < 3; k++) begin
        win[3*k]   <= win[3*k+1];
        win[3*k+1] <= win[3*k+2];
      end
      win[2] <= top1;
      win[5] <= mid1;
      win[8] <= pix1;
    end
  end

  // reduce stage
  logic     e2;
  win_ctl_t ctl2;

  always_ff @(posedge clk) begin
    if (rst) begin
      e2 <= 1'b0;
    end else begin
      e2 <= e1;
    end
  end

  always_ff @(posedge clk) begin
    ctl2 <= ctl1;
  end

  logic [7:0] ident;
  logic [7:0] nb [8];
  logic [7:0] l1 [4];
  logic [7:0] l2 [2];
  logic [7:0] result;

  always_comb begin
    ident = fmode ? PIX_MAX : 8'd0;
    nb[0] = (ctl2.top_ok && ctl2.left_ok)  ? win[0] : ident;
    nb[1] = ctl2.top_ok                    ? win[1] : ident;
    nb[2] = (ctl2.top_ok && ctl2.right_ok) ? win[2] : ident;
    nb[3] = ctl2.left_ok                   ? win[3] : ident;
    nb[4] = ctl2.right_ok                  ? win[5] : ident;
    nb[5] = (ctl2.bot_ok && ctl2.left_ok)  ? win[6] : ident;
    nb[6] = ctl2.bot_ok                    ? win[7] : ident;
    nb[7] = (ctl2.bot_ok && ctl2.right_ok) ? win[8] : ident;
    for (int i = 0; i < 4; i++) begin
      l1[i] = pick(nb[2*i], nb[2*i+1], fmode);
    end
    for (int i = 0; i < 2; i++) begin
      l2[i] = pick(l1[2*i], l1[2*i+1], fmode);
    end
    result = pick(l2[0], l2[1], fmode);
  end

  // output queue
  logic [8:0]    oq [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] cnt, occ;
  logic          push, pop;

  assign push     = e2;
  assign pop      = m_tvalid && m_tready;
  assign occ      = cnt + CW'(e1) + CW'(e2);
  assign s_tready = (occ < CW'(DEPTH));
  assign m_tvalid = (cnt != '0);
  assign m_tdata  = oq[rd_ptr][7:0];
  assign m_tlast  = oq[rd_ptr][8];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        cnt <= cnt + CW'(1);
      end else if (pop && !push) begin
        cnt <= cnt - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      oq[wr_ptr] <= {ctl2.last, result};
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= CW'(DEPTH))
    else $error("output queue overcommitted");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> (cnt < CW'(DEPTH)) || pop)
    else $error("push into full output queue");

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    in_column < AW'(w_c) || WW'(in_column) < w_c)
    else $error("input column past frame width");

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    in_row <= h_c)
    else $error("input row past frame height");

  a_s1_origin: assert property (@(posedge clk) disable iff (rst)
    v1 |-> $past(s_tvalid && s_tready))
    else $error("line-store stage busy without an accepted item");

endmodule

@@ tb/tb_grey_morph_3x3_minmax_top.sv @@
`timescale 1ns / 1ps
module tb_grey_morph_3x3_minmax_top;
  import gm3_pkg::*;

  localparam int unsigned MAX_W = 1024;
  localparam int unsigned MAX_H = 1024;
  localparam int SETTLE_CYCLES = 8;
  localparam int QUIET_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 300;
  localparam int HOLD_OFF_CYCLES = 400;

  localparam bit ACT_PUSH  = 1'b0;
  localparam bit ACT_FLUSH = 1'b1;

  // index with no register behind it
  localparam cfg_idx_t CFG_SPARE = 2'd3;

  typedef struct packed {
    logic [7:0] pixel;
    logic       last;
  } filt_result_t;

  logic                clk;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [7:0]          s_tdata = 8'h00;   // [7:0] pixel_in
  logic                s_tuser = 1'b0;    // [0] action
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [7:0]          m_tdata;           // [7:0] pixel_out
  logic                m_tlast;
  logic                cfg_we = 1'b0;
  cfg_idx_t            cfg_index = CFG_MODE;
  logic [CFG_DW-1:0]   cfg_data = '0;

  grey_morph_3x3_minmax_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // filter state as the block should hold it
  bit [7:0]    line_up  [MAX_W];
  bit [7:0]    line_mid [MAX_W];
  bit [7:0]    win [9];
  int unsigned in_col;
  int unsigned in_row;
  int unsigned out_pos;
  bit          use_min;
  bit [10:0]   width_reg = 11'd640;
  bit [10:0]   height_reg = 11'd480;

  filt_result_t pending_out[$];

  int send_idle_pct;
  int stall_pct;
  int rx_hold_req;
  int items_sent;
  int results_seen;
  int frames_seen;
  int mismatches;
  int quiet_cycles;

  function automatic int unsigned eff_size(input bit [10:0] v, input int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void restart_frame();
    in_col = 0;
    in_row = 0;
    out_pos = 0;
  endfunction

  function automatic bit frame_fresh();
    return in_col == 0 && in_row == 0 && out_pos == 0;
  endfunction

  function automatic void apply_config(input cfg_idx_t idx, input logic [10:0] val);
    case (idx)
      CFG_MODE: begin
        use_min = val[0];
      end
      CFG_WIDTH: begin
        width_reg = val;
        restart_frame();
      end
      CFG_HEIGHT: begin
        height_reg = val;
        restart_frame();
      end
      default: begin
      end
    endcase
  endfunction

  // advance the window by one item; queue the result it completes, if any
  function automatic bit morph_predict(input bit flush, input logic [7:0] pix_in);
    int unsigned w, h, n, r, c;
    logic [7:0] pix, top, mid, acc, v;
    bit last;
    w = eff_size(width_reg, MAX_W);
    h = eff_size(height_reg, MAX_H);
    // flush while the frame still takes pixels: dropped
    if (in_row < h && flush) return 1'b0;
    pix = (in_row < h) ? pix_in : 8'h00;
    n = in_row * w + in_col;
    top = line_up[in_col];
    mid = line_mid[in_col];
    line_up[in_col] = mid;
    line_mid[in_col] = pix;
    for (int k = 0; k < 3; k++) begin
      win[3*k] = win[3*k+1];
      win[3*k+1] = win[3*k+2];
    end
    win[2] = top;
    win[5] = mid;
    win[8] = pix;
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    if (n < w + 1) return 1'b1;
    r = out_pos / w;
    c = out_pos % w;
    acc = use_min ? PIX_MAX : 8'h00;
    for (int k = 0; k < 3; k++) begin
      for (int m = 0; m < 3; m++) begin
        if (k == 1 && m == 1) continue;
        if (k == 0 && r == 0) continue;
        if (k == 2 && r + 1 >= h) continue;
        if (m == 0 && c == 0) continue;
        if (m == 2 && c + 1 >= w) continue;
        v = win[3*k+m];
        if (use_min ? (v < acc) : (v > acc)) acc = v;
      end
    end
    last = (out_pos + 1 >= w * h);
    pending_out.push_back('{pixel: acc, last: last});
    if (last) restart_frame();
    else out_pos++;
    return 1'b1;
  endfunction

  function automatic logic [7:0] rand_pixel();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return PIX_MAX;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [10:0] random_size(input int unsigned big);
    int unsigned pick_pct;
    pick_pct = $urandom_range(99);
    if (pick_pct < 5) return 11'd0;
    if (pick_pct < 15) return 11'($urandom_range(big, 1));
    return 11'($urandom_range(8, 1));
  endfunction

  task automatic set_idling(input int phase);
    case (phase % 4)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 63; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 63; end
      default: begin send_idle_pct = 32; stall_pct = 32; end
    endcase
  endtask

  task automatic send_item(input bit flush, input logic [7:0] pix);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= pix;
    s_tuser <= flush;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (morph_predict(flush, pix)) items_sent++;
  endtask

  // hold the input until every expected result is out, then let the pipe empty
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [10:0] val);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    apply_config(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_mode(input bit want_min);
    write_reg(CFG_MODE, {10'($urandom), want_min});
  endtask

  task automatic send_pixels(input int count, input int noise_pct);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < noise_pct) send_item(ACT_FLUSH, rand_pixel());
      send_item(ACT_PUSH, rand_pixel());
    end
  endtask

  // push the tail out; pushes here only carry discarded pixels
  task automatic drain_frame();
    repeat (eff_size(width_reg, MAX_W) + 1) send_item(1'($urandom_range(1)), rand_pixel());
  endtask

  task automatic send_frame(input int noise_pct);
    send_pixels(eff_size(width_reg, MAX_W) * eff_size(height_reg, MAX_H), noise_pct);
    drain_frame();
  endtask

  // 640x480 out of reset: no result until a full row plus one pixel is in
  task automatic test_reset_defaults();
    set_idling(0);
    send_pixels(20, 20);
    settle();
  endtask

  task automatic test_small_frames();
    set_idling(0);
    write_reg(CFG_WIDTH, 11'd3);
    write_reg(CFG_HEIGHT, 11'd3);
    send_item(ACT_PUSH, 8'd0);
    send_item(ACT_PUSH, 8'd255);
    send_item(ACT_PUSH, 8'd1);
    send_item(ACT_PUSH, 8'd128);
    send_item(ACT_FLUSH, 8'd77);
    send_item(ACT_PUSH, 8'd127);
    send_item(ACT_PUSH, 8'd254);
    send_item(ACT_PUSH, 8'd85);
    send_item(ACT_PUSH, 8'd170);
    send_item(ACT_PUSH, 8'd255);
    send_item(ACT_FLUSH, 8'd0);
    send_item(ACT_PUSH, 8'd200);
    send_item(ACT_FLUSH, 8'd255);
    send_item(ACT_FLUSH, 8'd0);
    // zero sizes act as one: single pixel with no neighbours
    write_reg(CFG_WIDTH, 11'd0);
    write_reg(CFG_HEIGHT, 11'd0);
    send_item(ACT_PUSH, 8'd255);
    send_item(ACT_FLUSH, 8'd0);
    send_item(ACT_FLUSH, 8'd0);
    write_mode(1'b1);
    write_reg(CFG_WIDTH, 11'd2);
    write_reg(CFG_HEIGHT, 11'd2);
    send_item(ACT_PUSH, 8'd0);
    send_item(ACT_PUSH, 8'd255);
    send_item(ACT_PUSH, 8'd255);
    send_item(ACT_PUSH, 8'd0);
    drain_frame();
  endtask

  task automatic test_size_limits();
    set_idling(0);
    write_mode(1'b0);
    // zero width acts as one: a single column
    write_reg(CFG_WIDTH, 11'd0);
    write_reg(CFG_HEIGHT, 11'd6);
    send_frame(0);
    // zero height acts as one: a single row
    write_mode(1'b1);
    write_reg(CFG_WIDTH, 11'd9);
    write_reg(CFG_HEIGHT, 11'd0);
    send_frame(0);
    // oversized values clamp to the maximum; no result before a full row
    write_reg(CFG_WIDTH, 11'd2047);
    write_reg(CFG_HEIGHT, 11'd1025);
    send_pixels(12, 0);
    settle();
  endtask

  task automatic test_mid_frame_writes();
    set_idling(3);
    write_mode(1'b0);
    write_reg(CFG_WIDTH, 11'd5);
    write_reg(CFG_HEIGHT, 11'd4);
    send_pixels(9, 10);
    write_reg(CFG_SPARE, 11'($urandom));
    send_pixels(3, 10);
    write_mode(1'b1);
    send_pixels(8, 10);
    drain_frame();
    send_pixels(7, 0);
    write_reg(CFG_HEIGHT, 11'd3);
    send_frame(10);
  endtask

  task automatic test_backpressure();
    set_idling(0);
    write_mode(1'b0);
    write_reg(CFG_WIDTH, 11'd16);
    write_reg(CFG_HEIGHT, 11'd8);
    rx_hold_req = HOLD_OFF_CYCLES;
    send_frame(0);
    set_idling(3);
    send_pixels(50, 5);
    settle();
    send_pixels(78, 5);
    drain_frame();
  endtask

  task automatic test_random_frames();
    int start_count, frame_idx, npix, cut, split;
    start_count = items_sent;
    frame_idx = 0;
    while (items_sent < start_count + RANDOM_ITEMS) begin
      set_idling(frame_idx);
      if (!frame_fresh() || $urandom_range(99) < 60) begin
        if (!frame_fresh() || $urandom_range(1)) write_reg(CFG_WIDTH, random_size(40));
        if ($urandom_range(1)) write_reg(CFG_HEIGHT, random_size(12));
        if ($urandom_range(1)) write_mode(1'($urandom));
      end
      npix = eff_size(width_reg, MAX_W) * eff_size(height_reg, MAX_H);
      cut = ($urandom_range(99) < 10) ? $urandom_range(npix - 1) : npix;
      if ($urandom_range(99) < 15) begin
        split = $urandom_range(cut);
        send_pixels(split, 5);
        write_mode(1'($urandom));
        send_pixels(cut - split, 5);
      end else begin
        send_pixels(cut, 5);
      end
      if (cut == npix) drain_frame();
      frame_idx++;
    end
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (rx_hold_req > 0) begin
        // long hold-off: input side keeps offering until the block backs up
        for (int i = 0; i < rx_hold_req; i++) begin
          m_tready <= 1'b0;
          @(posedge clk);
        end
        rx_hold_req = 0;
      end
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    filt_result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = '{pixel: m_tdata, last: m_tlast};
      if (pending_out.size() == 0) begin
        $error("unexpected result: pixel_out=%0d frame_last=%0b", got.pixel, got.last);
        mismatches++;
      end else begin
        want = pending_out.pop_front();
        results_seen++;
        if (got.last === 1'b1) frames_seen++;
        if (got.pixel !== want.pixel) begin
          $error("pixel_out: expected %0d, got %0d", want.pixel, got.pixel);
          mismatches++;
        end
        if (got.last !== want.last) begin
          $error("frame_last: expected %0b, got %0b", want.last, got.last);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: %0d cycles with no item moving", quiet_cycles);
      $display("tb_grey_morph_3x3_minmax_top: errors");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_small_frames();
    test_size_limits();
    test_mid_frame_writes();
    test_backpressure();
    test_random_frames();
    settle();
    $display("covered %0d items, %0d results, %0d frames: max and min, sizes 1 to 40,",
             items_sent, results_seen, frames_seen);
    $display("zero and oversized sizes, mid-frame writes, early flushes, long output");
    $display("hold-off and four idle mixes");
    if (mismatches == 0) begin
      $display("tb_grey_morph_3x3_minmax_top: clean");
    end else begin
      $display("tb_grey_morph_3x3_minmax_top: errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/gm3_pkg.sv
rtl/gm3_ram.sv
rtl/grey_morph_3x3_minmax_top.sv
tb/tb_grey_morph_3x3_minmax_top.sv
